// File: design/flow_pinned_least_load_balancer_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the flow balancer
// ---------------------------------------------------------------------------
`ifndef FLOW_PINNED_LEAST_LOAD_BALANCER_TOP_MACROS_SVH
`define FLOW_PINNED_LEAST_LOAD_BALANCER_TOP_MACROS_SVH

// same-cycle implication
`define FLPL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FLPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/flpl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flpl_pkg
// Types and constants shared by the flow balancer modules.
// ---------------------------------------------------------------------------
package flpl_pkg;

   typedef struct packed {
      logic [31:0] arrival_ms;
      logic [15:0] src_host;
      logic [15:0] dst_host;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] payload_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  chosen_link;
      logic        new_flow;
      logic [1:0]  rr_link;
      logic        in_window;
      logic [11:0] window_index;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic load_in;
      logic hash1;
      logic hash2;
      logic hash3;
      logic read;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
   } status_type;

   // register index, taken from paddr[2]
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   localparam logic [29:0] WINDOW_RESET     = 30'd300000;
   localparam logic [11:0] WINDOW_COUNT_MAX = 12'd4095;

   // lane hash: (src_host * HASH_MUL) mod LANE_MOD, folded to a 12-bit multiplier
   localparam logic [63:0] HASH_MUL   = 64'd1099511628211;
   localparam logic [11:0] LANE_MOD   = 12'd3233;
   localparam logic [11:0] LANE_MUL   = 12'(HASH_MUL % 64'(LANE_MOD));
   localparam logic [31:0] LANE_RECIP = 32'((64'd1 << 32) / 64'(LANE_MOD));

endpackage

// File: design/flpl_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flpl_csr
// APB register slice holding the window length.
// ---------------------------------------------------------------------------
module flpl_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [29:0] window_length
);

   logic [29:0] window_length_ff;
   logic [29:0] window_length_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite &&
                  (csr_paddr[2] == flpl_pkg::REG_WINDOW_LENGTH);

   always_comb begin
      window_length_in = window_length_ff;
      if (wr_en) begin
         window_length_in = csr_pwdata[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= flpl_pkg::WINDOW_RESET;
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == flpl_pkg::REG_WINDOW_LENGTH) begin
         csr_prdata = {2'b00, window_length_ff};
      end
   end

   assign window_length = window_length_ff;

endmodule

// File: design/flpl_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flpl_ctrl
// Sequencer: table clear after reset, then hash, read and commit per request.
// ---------------------------------------------------------------------------
module flpl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  flpl_pkg::status_type status,
   output flpl_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH1,
      S_HASH2,
      S_HASH3,
      S_READ,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in     = S_IDLE;
               req_ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load_in  = 1'b1;
               req_ready_in = 1'b0;
               state_in     = S_HASH1;
            end
         end
         S_HASH1: begin
            cmd.hash1 = 1'b1;
            state_in  = S_HASH2;
         end
         S_HASH2: begin
            cmd.hash2 = 1'b1;
            state_in  = S_HASH3;
         end
         S_HASH3: begin
            cmd.hash3 = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // hold here until the output register can take the result
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in     = S_CLEAR;
            req_ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/flpl_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flpl_dp
// Datapath: flow hash, flow table, link loads, window tracking, result.
// ---------------------------------------------------------------------------
module flpl_dp #(
   parameter int unsigned HASH_MOD = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  flpl_pkg::cmd_type    cmd,
   output flpl_pkg::status_type status,
   input  flpl_pkg::req_type    req_data,
   input  logic [29:0]          window_length,
   output flpl_pkg::rsp_type    rsp_data
);

   localparam int RC_W  = $clog2(HASH_MOD);
   localparam int RC2_W = $clog2(HASH_MOD * HASH_MOD);
   localparam int IDX_W = RC2_W + 2;
   localparam int DEPTH = HASH_MOD * HASH_MOD * 4;
   localparam logic [12:0] MOD_C     = 13'(HASH_MOD);
   localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / 64'(HASH_MOD));

   // request and hash pipeline registers
   flpl_pkg::req_type in_ff;
   logic [15:0]       row_q_ff, col_q_ff;
   logic [27:0]       lane_p_ff;
   logic [17:0]       lane_q_ff;
   logic [RC_W-1:0]   row_ff, col_ff;
   logic [RC2_W-1:0]  rowcol_ff;
   logic [1:0]        lane_ff;
   logic [2:0]        ent_ff;
   logic [1:0]        least_ff;
   logic              in_win_ff;
   flpl_pkg::rsp_type rsp_ff;

   logic [2:0] flow_mem [DEPTH];

   // control state
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic signed [31:0] load_ff [4];
   logic signed [31:0] load_in [4];
   logic [1:0]        rr_ff, rr_in;
   logic [31:0]       win_start_ff, win_start_in;
   logic              started_ff, started_in;
   logic [11:0]       win_cnt_ff, win_cnt_in;

   // hash stage 1
   logic [15:0] row_x, col_x;
   logic [47:0] row_prod, col_prod;
   logic [27:0] lane_p_in;
   // hash stage 2
   logic [28:0] row_qm, col_qm;
   logic [15:0] row_r, col_r, row_fold, col_fold;
   logic [49:0] lane_prod;
   // hash stage 3
   logic [29:0] lane_qm;
   logic [27:0] lane_r, lane_fold;
   logic [RC_W+13:0] rc_sum;
   // table read and commit
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   logic [2:0]       wr_data;
   logic [3:0]       low;
   logic [1:0]       least_in;
   logic [31:0]      win_base;
   logic             in_win_in;
   logic             hit;
   logic [1:0]       link;
   logic [32:0]      sum;
   logic signed [31:0] sat_load;
   flpl_pkg::rsp_type rsp_in;

   assign row_x     = in_ff.src_host ^ in_ff.dst_host;
   assign col_x     = in_ff.src_port ^ in_ff.dst_port;
   assign row_prod  = 48'(row_x) * 48'(MOD_RECIP);
   assign col_prod  = 48'(col_x) * 48'(MOD_RECIP);
   assign lane_p_in = 28'(in_ff.src_host) * 28'(flpl_pkg::LANE_MUL);

   // reciprocal estimate is low by at most one, so one fold corrects it
   assign row_qm    = 29'(row_q_ff) * 29'(MOD_C);
   assign col_qm    = 29'(col_q_ff) * 29'(MOD_C);
   assign row_r     = row_x - row_qm[15:0];
   assign col_r     = col_x - col_qm[15:0];
   assign row_fold  = (row_r >= 16'(MOD_C)) ? row_r - 16'(MOD_C) : row_r;
   assign col_fold  = (col_r >= 16'(MOD_C)) ? col_r - 16'(MOD_C) : col_r;
   assign lane_prod = 50'(lane_p_ff) * 50'(flpl_pkg::LANE_RECIP);

   assign lane_qm   = 30'(lane_q_ff) * 30'(flpl_pkg::LANE_MOD);
   assign lane_r    = lane_p_ff - lane_qm[27:0];
   assign lane_fold = (lane_r >= 28'(flpl_pkg::LANE_MOD)) ?
                      lane_r - 28'(flpl_pkg::LANE_MOD) : lane_r;
   assign rc_sum    = (RC_W+14)'(row_ff) * (RC_W+14)'(MOD_C) + (RC_W+14)'(col_ff);

   assign rd_addr = {rowcol_ff, lane_ff};

   // last link whose load is no greater than every other one
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         low[i] = 1'b1;
         for (int j = 0; j < 4; j++) begin
            if (j != i && load_ff[i] > load_ff[j]) begin
               low[i] = 1'b0;
            end
         end
      end
      if (low[3]) begin
         least_in = 2'd3;
      end else if (low[2]) begin
         least_in = 2'd2;
      end else if (low[1]) begin
         least_in = 2'd1;
      end else begin
         least_in = 2'd0;
      end
   end

   // first request opens the window at its own arrival time
   assign win_base  = started_ff ? win_start_ff : in_ff.arrival_ms;
   assign in_win_in = {1'b0, in_ff.arrival_ms} < ({1'b0, win_base} + {3'b000, window_length});

   assign hit      = ent_ff[2];
   assign link     = hit ? ent_ff[1:0] : least_ff;
   assign sum      = {load_ff[link][31], load_ff[link]} + {17'd0, in_ff.payload_bytes};
   assign sat_load = (!sum[32] && sum[31]) ? 32'sh7FFF_FFFF : $signed(sum[31:0]);

   assign wr_en   = cmd.clear_step || (cmd.commit && !hit);
   assign wr_addr = cmd.clear_step ? clr_cnt_ff : rd_addr;
   assign wr_data = cmd.clear_step ? 3'b000 : {1'b1, least_ff};

   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      rr_in        = rr_ff;
      win_start_in = win_start_ff;
      started_in   = started_ff;
      win_cnt_in   = win_cnt_ff;
      for (int k = 0; k < 4; k++) begin
         load_in[k] = load_ff[k];
      end
      rsp_in = rsp_ff;
      if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + IDX_W'(1);
      end
      if (cmd.commit) begin
         started_in = 1'b1;
         rsp_in.chosen_link = link;
         rsp_in.new_flow    = !hit;
         rsp_in.in_window   = in_win_ff;
         if (in_win_ff) begin
            load_in[link]  = sat_load;
            rr_in          = rr_ff + 2'd1;
            win_start_in   = win_base;
            rsp_in.rr_link = rr_ff;
         end else begin
            load_in[0]     = 32'sd4;
            load_in[1]     = 32'sd3;
            load_in[2]     = 32'sd2;
            load_in[3]     = 32'sd1;
            win_start_in   = in_ff.arrival_ms;
            rsp_in.rr_link = 2'd0;
            if (win_cnt_ff < flpl_pkg::WINDOW_COUNT_MAX) begin
               win_cnt_in = win_cnt_ff + 12'd1;
            end
         end
         rsp_in.window_index = win_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rr_ff        <= 2'd0;
         win_start_ff <= 32'd0;
         started_ff   <= 1'b0;
         win_cnt_ff   <= 12'd0;
         load_ff[0]   <= -32'sd4;
         load_ff[1]   <= -32'sd3;
         load_ff[2]   <= -32'sd2;
         load_ff[3]   <= -32'sd1;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rr_ff        <= rr_in;
         win_start_ff <= win_start_in;
         started_ff   <= started_in;
         win_cnt_ff   <= win_cnt_in;
         for (int k = 0; k < 4; k++) begin
            load_ff[k] <= load_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load_in) begin
         in_ff <= req_data;
      end
      if (cmd.hash1) begin
         row_q_ff  <= row_prod[47:32];
         col_q_ff  <= col_prod[47:32];
         lane_p_ff <= lane_p_in;
      end
      if (cmd.hash2) begin
         row_ff    <= row_fold[RC_W-1:0];
         col_ff    <= col_fold[RC_W-1:0];
         lane_q_ff <= lane_prod[49:32];
      end
      if (cmd.hash3) begin
         rowcol_ff <= rc_sum[RC2_W-1:0];
         lane_ff   <= lane_fold[1:0];
      end
      if (cmd.read) begin
         least_ff  <= least_in;
         in_win_ff <= in_win_in;
      end
   end

   // flow table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         flow_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         ent_ff <= flow_mem[rd_addr];
      end
   end

   assign status.clear_last = (clr_cnt_ff == IDX_W'(DEPTH - 1));
   assign rsp_data = rsp_ff;

endmodule

// File: design/flow_pinned_least_load_balancer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flow_pinned_least_load_balancer_top
// Flow-pinned least-load balancer over four links.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one packet request (valid/ready). rsp_* returns one result
//   per request: pinned link, new-flow flag, round-robin link, window status
//   and window number. csr_* is an APB port; window_length is at address 0.
//   A taken request passes the hash1, hash2, hash3, read and commit steps to
//   rsp_data, and the next one waits for commit, behind the three-step
//   reciprocal multiply chain of the hash and the registered flow table read.
//   The result sits in an output register, so the next request is taken
//   while a result still waits; if that result is still held when the next
//   one is ready, the sequencer waits in its commit step until rsp_ready.
//   Reset: synchronous. Afterwards the flow table is cleared one entry per
//   cycle, all 4*HASH_MOD*HASH_MOD entries (16384 at the default); req_ready
//   stays low through the clear, register writes are taken throughout.
// ---------------------------------------------------------------------------
`include "flow_pinned_least_load_balancer_top_macros.svh"

module flow_pinned_least_load_balancer_top #(
   parameter int unsigned HASH_MOD = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  flpl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output flpl_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   flpl_pkg::cmd_type    cmd;
   flpl_pkg::status_type status;
   logic [29:0]          window_length;

   flpl_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .window_length (window_length)
   );

   flpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   flpl_dp #(
      .HASH_MOD (HASH_MOD)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .window_length (window_length),
      .rsp_data      (rsp_data)
   );

   `FLPL_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while another is in flight")
   `FLPL_ASSERT_NOW(a_commit_slot_free, clock, reset, cmd.commit, !rsp_valid || rsp_ready, "result committed over an unread result")
   `FLPL_ASSERT_NOW(a_no_accept_in_clear, clock, reset, cmd.clear_step, !req_ready, "request port open during table clear")
   `FLPL_ASSERT_NOW(a_rr_zero_closed, clock, reset, rsp_valid, rsp_data.in_window || (rsp_data.rr_link == 2'd0), "round-robin link set on a closed window")

endmodule
